// File: rtl/core/hrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types, constants and the hex digit decoder for the record parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ADDR_W   = 16;

  localparam logic [CHAR_W-1:0]   CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0]   CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]   CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0]   CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0]   CHAR_UP_F  = 8'h46;
  localparam logic [NIBBLE_W-1:0] ALPHA_OFS  = 4'd9;

  localparam logic [BYTE_W-1:0] KIND_EOF = 8'h01;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] character;
    logic              last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic [ADDR_W-1:0] byte_address;
    logic              end_marker;
  } result_t;

  // '0'-'9' and 'A'-'F' only; anything else reads as zero
  function automatic logic [NIBBLE_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [NIBBLE_W-1:0] v;
    v = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c[NIBBLE_W-1:0];
    end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
      v = c[NIBBLE_W-1:0] + ALPHA_OFS;
    end
    return v;
  endfunction

endpackage

// File: rtl/core/hrp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_in_stage
// Input register: captures one character per transfer and holds it until
// the parse stage advances.
// ----------------------------------------------------------------------------
module hrp_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hrp_pkg::CHAR_W-1:0]  in_character,
  input  logic                        in_last_in_buffer,
  input  logic                        advance,
  output hrp_pkg::in_item_t           item
);

  logic                       valid_r, valid_nxt;
  logic [hrp_pkg::CHAR_W-1:0] char_r;
  logic                       last_r;
  logic                       take;

  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      char_r <= in_character;
      last_r <= in_last_in_buffer;
    end
  end

  assign item.valid          = valid_r;
  assign item.character      = char_r;
  assign item.last_in_buffer = last_r;

endmodule

// File: rtl/core/hrp_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_parse_core
// Record state machine: consumes one character per advance and produces at
// most one data byte or end marker.
// ----------------------------------------------------------------------------
module hrp_parse_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  hrp_pkg::in_item_t item,
  output logic              res_valid,
  output hrp_pkg::result_t  res
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_COUNT = 3'd1,
    PH_ADDR  = 3'd2,
    PH_KIND  = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [1:0]                   digit_r, digit_nxt;
  logic [hrp_pkg::NIBBLE_W-1:0] high_r, high_nxt;
  logic [hrp_pkg::BYTE_W-1:0]   left_r, left_nxt;
  logic [hrp_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [hrp_pkg::BYTE_W-1:0]   kind_r, kind_nxt;
  logic                         finished_r, finished_nxt;
  logic [hrp_pkg::NIBBLE_W-1:0] d;
  logic [hrp_pkg::BYTE_W-1:0]   pair;
  logic [hrp_pkg::BYTE_W-1:0]   left_dec;

  assign d        = hrp_pkg::hex_value(item.character);
  assign pair     = {high_r, d};
  assign left_dec = left_r - 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    digit_nxt        = digit_r;
    high_nxt         = high_r;
    left_nxt         = left_r;
    addr_nxt         = addr_r;
    kind_nxt         = kind_r;
    finished_nxt     = finished_r;
    res_valid        = 1'b0;
    res.byte_value   = '0;
    res.byte_address = '0;
    res.end_marker   = 1'b0;

    if (!finished_r) begin
      case (phase_r)
        PH_COUNT: begin
          if (digit_r == 2'd0) begin
            high_nxt  = d;
            digit_nxt = 2'd1;
          end else begin
            left_nxt  = pair;
            digit_nxt = 2'd0;
            phase_nxt = PH_ADDR;
          end
        end
        PH_ADDR: begin
          addr_nxt  = {addr_r[hrp_pkg::ADDR_W-hrp_pkg::NIBBLE_W-1:0], d};
          digit_nxt = digit_r + 2'd1;
          if (digit_r == 2'd3) begin
            phase_nxt = PH_KIND;
          end
        end
        PH_KIND: begin
          if (digit_r == 2'd0) begin
            high_nxt  = d;
            digit_nxt = 2'd1;
          end else begin
            kind_nxt  = pair;
            digit_nxt = 2'd0;
            if (pair == hrp_pkg::KIND_EOF) begin
              res_valid      = 1'b1;
              res.end_marker = 1'b1;
              finished_nxt   = 1'b1;
              phase_nxt      = PH_HUNT;
            end else if (left_r == '0) begin
              phase_nxt = PH_HUNT;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (digit_r == 2'd0) begin
            high_nxt  = d;
            digit_nxt = 2'd1;
          end else begin
            digit_nxt        = 2'd0;
            res_valid        = 1'b1;
            res.byte_value   = pair;
            res.byte_address = addr_r;
            addr_nxt         = addr_r + 16'd1;
            left_nxt         = left_dec;
            if (left_dec == '0) begin
              phase_nxt = PH_HUNT;
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (item.character == hrp_pkg::CHAR_COLON) begin
            phase_nxt = PH_COUNT;
            digit_nxt = 2'd0;
          end
        end
      endcase
    end

    // end of buffer: drop any partial record and rearm
    if (item.last_in_buffer) begin
      phase_nxt    = PH_HUNT;
      digit_nxt    = 2'd0;
      finished_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      digit_r    <= '0;
      high_r     <= '0;
      left_r     <= '0;
      addr_r     <= '0;
      kind_r     <= '0;
      finished_r <= 1'b0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      digit_r    <= digit_nxt;
      high_r     <= high_nxt;
      left_r     <= left_nxt;
      addr_r     <= addr_nxt;
      kind_r     <= kind_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

// File: rtl/core/hex_record_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_parser_unit
// Streaming parser for hex text records, one character per transfer.
// Path: each character is held in the input register, and its result, if any, is registered in the result register.
// Throughput: one character per cycle while the output is not stalled.
// Reset: synchronous, clears the parser state and empties both pipeline registers.
// ----------------------------------------------------------------------------
module hex_record_parser_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hrp_pkg::CHAR_W-1:0]  in_character,
  input  logic                        in_last_in_buffer,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hrp_pkg::BYTE_W-1:0]  out_byte_value,
  output logic [hrp_pkg::ADDR_W-1:0]  out_byte_address,
  output logic                        out_end_marker
);

  hrp_pkg::in_item_t item;
  hrp_pkg::result_t  res;
  hrp_pkg::result_t  out_r;
  logic              res_valid;
  logic              advance;
  logic              out_valid_r, out_valid_nxt;

  // advance when the result register is empty or being drained
  assign advance = item.valid && (!out_valid_r || !out_stall);

  hrp_in_stage u_in (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_character      (in_character),
    .in_last_in_buffer (in_last_in_buffer),
    .advance           (advance),
    .item              (item)
  );

  hrp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_value   = out_r.byte_value;
  assign out_byte_address = out_r.byte_address;
  assign out_end_marker   = out_r.end_marker;

endmodule

// File: verif/hrp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_result_checker
// Watches both channels of the hex record parser, tracks the parse state of
// every accepted character, queues the data bytes and end markers that must
// come out, and compares each result transfer against the oldest one queued.
// ----------------------------------------------------------------------------
module hrp_result_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [hrp_pkg::CHAR_W-1:0]  in_character,
  input  logic                        in_last_in_buffer,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [hrp_pkg::BYTE_W-1:0]  out_byte_value,
  input  logic [hrp_pkg::ADDR_W-1:0]  out_byte_address,
  input  logic                        out_end_marker,
  output int unsigned                 mismatches,
  output int unsigned                 bytes_due
);

  typedef enum logic [2:0] {
    SEEK_COLON,
    READ_COUNT,
    READ_ADDR,
    READ_KIND,
    READ_DATA
  } parse_step_t;

  parse_step_t                step;
  logic [1:0]                 digit_idx;
  logic [3:0]                 upper_nib;
  logic [hrp_pkg::BYTE_W-1:0] bytes_left;
  logic [hrp_pkg::ADDR_W-1:0] load_addr;
  logic [hrp_pkg::BYTE_W-1:0] rec_kind;
  logic                       eof_seen;

  hrp_pkg::result_t           due_results[$];
  hrp_pkg::result_t           oldest;

  initial begin
    mismatches = 0;
    bytes_due  = 0;
  end

  function automatic logic [3:0] digit_value(input logic [hrp_pkg::CHAR_W-1:0] c);
    logic [hrp_pkg::CHAR_W-1:0] diff;
    diff = 8'd0;
    if (c >= hrp_pkg::CHAR_ZERO && c <= hrp_pkg::CHAR_NINE) begin
      diff = c - hrp_pkg::CHAR_ZERO;
    end else if (c >= hrp_pkg::CHAR_UP_A && c <= hrp_pkg::CHAR_UP_F) begin
      diff = c - hrp_pkg::CHAR_UP_A + 8'd10;
    end
    return diff[3:0];
  endfunction

  task automatic parse_char(input logic [hrp_pkg::CHAR_W-1:0] c, input logic last);
    logic [3:0]       d;
    hrp_pkg::result_t r;
    d = digit_value(c);
    if (!eof_seen) begin
      case (step)
        READ_COUNT: begin
          if (digit_idx == 2'd0) begin
            upper_nib = d;
            digit_idx = 2'd1;
          end else begin
            bytes_left = {upper_nib, d};
            digit_idx  = 2'd0;
            step       = READ_ADDR;
          end
        end
        READ_ADDR: begin
          load_addr = {load_addr[hrp_pkg::ADDR_W-5:0], d};
          if (digit_idx == 2'd3) begin
            step = READ_KIND;
          end
          digit_idx = digit_idx + 2'd1;
        end
        READ_KIND: begin
          if (digit_idx == 2'd0) begin
            upper_nib = d;
            digit_idx = 2'd1;
          end else begin
            rec_kind  = {upper_nib, d};
            digit_idx = 2'd0;
            if (rec_kind == hrp_pkg::KIND_EOF) begin
              r.byte_value   = '0;
              r.byte_address = '0;
              r.end_marker   = 1'b1;
              due_results.push_back(r);
              eof_seen = 1'b1;
              step     = SEEK_COLON;
            end else if (bytes_left == 8'd0) begin
              step = SEEK_COLON;
            end else begin
              step = READ_DATA;
            end
          end
        end
        READ_DATA: begin
          if (digit_idx == 2'd0) begin
            upper_nib = d;
            digit_idx = 2'd1;
          end else begin
            digit_idx      = 2'd0;
            r.byte_value   = {upper_nib, d};
            r.byte_address = load_addr;
            r.end_marker   = 1'b0;
            due_results.push_back(r);
            load_addr  = load_addr + 16'd1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) begin
              step = SEEK_COLON;
            end
          end
        end
        default: begin
          step = SEEK_COLON;
          if (c == hrp_pkg::CHAR_COLON) begin
            step      = READ_COUNT;
            digit_idx = 2'd0;
          end
        end
      endcase
    end
    // end of buffer drops any partial record and clears the end-of-file hold
    if (last) begin
      step      = SEEK_COLON;
      digit_idx = 2'd0;
      eof_seen  = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step       = SEEK_COLON;
      digit_idx  = 2'd0;
      upper_nib  = 4'd0;
      bytes_left = 8'd0;
      load_addr  = 16'd0;
      rec_kind   = 8'd0;
      eof_seen   = 1'b0;
      due_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        parse_char(in_character, in_last_in_buffer);
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: byte_value %0h byte_address %0h end_marker %0b",
                 out_byte_value, out_byte_address, out_end_marker);
          mismatches++;
        end else begin
          oldest = due_results.pop_front();
          if (out_byte_value !== oldest.byte_value) begin
            $error("byte_value: expected %0h, got %0h", oldest.byte_value, out_byte_value);
            mismatches++;
          end
          if (out_byte_address !== oldest.byte_address) begin
            $error("byte_address: expected %0h, got %0h",
                   oldest.byte_address, out_byte_address);
            mismatches++;
          end
          if (out_end_marker !== oldest.end_marker) begin
            $error("end_marker: expected %0b, got %0b", oldest.end_marker, out_end_marker);
            mismatches++;
          end
        end
      end
    end
    bytes_due <= due_results.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for hex_record_parser_unit. Sends directed record text, then
// random well-formed, truncated and noisy records with random gaps and output
// stalls, including one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RANDOM_CHARS = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [hrp_pkg::CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [hrp_pkg::CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [hrp_pkg::CHAR_W-1:0] CHAR_CR    = 8'h0D;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [hrp_pkg::CHAR_W-1:0] in_character = '0;
  logic                       in_last_in_buffer = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [hrp_pkg::BYTE_W-1:0] out_byte_value;
  logic [hrp_pkg::ADDR_W-1:0] out_byte_address;
  logic                       out_end_marker;

  int unsigned mismatches;
  int unsigned bytes_due;
  int unsigned chars_sent = 0;
  int unsigned cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_started = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hex_record_parser_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_character      (in_character),
    .in_last_in_buffer (in_last_in_buffer),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte_value    (out_byte_value),
    .out_byte_address  (out_byte_address),
    .out_end_marker    (out_end_marker)
  );

  hrp_result_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_character      (in_character),
    .in_last_in_buffer (in_last_in_buffer),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte_value    (out_byte_value),
    .out_byte_address  (out_byte_address),
    .out_end_marker    (out_end_marker),
    .mismatches        (mismatches),
    .bytes_due         (bytes_due)
  );

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // mostly uppercase digits, now and then lowercase or an arbitrary byte
  function automatic void push_hex(ref logic [hrp_pkg::CHAR_W-1:0] q[$],
                                   input logic [7:0] v);
    logic [3:0]  nib;
    int unsigned r;
    for (int k = 1; k >= 0; k--) begin
      nib = (k == 1) ? v[7:4] : v[3:0];
      r = $urandom_range(0, 99);
      if (r < 3) begin
        q.push_back(8'($urandom_range(0, 255)));
      end else if (nib < 4'd10) begin
        q.push_back(hrp_pkg::CHAR_ZERO + 8'(nib));
      end else if (r < 6) begin
        q.push_back(CHAR_LOW_A + 8'(nib) - 8'd10);
      end else begin
        q.push_back(hrp_pkg::CHAR_UP_A + 8'(nib) - 8'd10);
      end
    end
  endfunction

  task automatic send_char(input logic [hrp_pkg::CHAR_W-1:0] c, input logic last);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_character      <= c;
    in_last_in_buffer <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  task automatic send_line(ref logic [hrp_pkg::CHAR_W-1:0] q[$], input int n,
                           input bit last_at_end);
    for (int i = 0; i < n; i++) begin
      send_char(q[i], last_at_end && (i == n - 1));
    end
  endtask

  task automatic build_record(ref logic [hrp_pkg::CHAR_W-1:0] q[$], input logic [7:0] count,
                              input logic [15:0] addr, input logic [7:0] kind);
    q.delete();
    q.push_back(hrp_pkg::CHAR_COLON);
    push_hex(q, count);
    push_hex(q, addr[15:8]);
    push_hex(q, addr[7:0]);
    push_hex(q, kind);
    for (int i = 0; i < count; i++) begin
      push_hex(q, 8'($urandom_range(0, 255)));
    end
    push_hex(q, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 0) begin
      q.push_back(CHAR_CR);
      q.push_back(CHAR_LF);
    end
  endtask

  // receiver: random stalls in short bursts, free stretches, one long hold-off
  initial begin : receiver
    int unsigned r;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (r < 50) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r < 95) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("hex_record_parser_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [hrp_pkg::CHAR_W-1:0] line[$];
    logic [7:0]                 count;
    logic [7:0]                 kind;
    logic [15:0]                addr;
    int unsigned                pick;
    int unsigned                sel;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed records
    send_text(":0000000000", 1'b0);            // zero count, nothing out
    send_text(":0300100000FF80AA", 1'b0);      // byte extremes
    send_text(":04FFFE00A55A0102CC", 1'b0);    // address wraps past FFFF
    send_text(":02000000agZ:\r\n", 1'b0);       // lowercase and junk digits read as zero
    send_text(":01001005C3", 1'b0);            // unknown type handled as data
    send_text(":g2zz0000q1w2", 1'b0);          // junk digits in the header
    send_text(":0400", 1'b1);                  // buffer ends mid-record
    send_text(":FF00000012", 1'b1);            // large count cut short
    send_text(":00000001FF:0100000011", 1'b1); // end marker, rest ignored
    send_text(":01000000EE", 1'b1);

    // long output hold-off while a long record keeps arriving
    hold_req = 1'b1;
    in_valid <= 1'b0;
    do @(posedge clk); while (!hold_started);
    no_idle = 1'b1;
    build_record(line, 8'd64, 16'($urandom_range(0, 65535)), 8'h00);
    send_line(line, line.size(), 1'b0);

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      pick    = $urandom_range(0, 99);
      sel     = $urandom_range(0, 99);
      if (sel < 85) begin
        count = 8'($urandom_range(0, 8));
      end else if (sel < 98) begin
        count = 8'($urandom_range(9, 32));
      end else begin
        count = 8'hFF;
      end
      if ($urandom_range(0, 3) == 0) begin
        addr = 16'hFFF0 | 16'($urandom_range(0, 15));
      end else begin
        addr = 16'($urandom_range(0, 65535));
      end
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        kind = 8'h00;
      end else if (sel < 90) begin
        kind = hrp_pkg::KIND_EOF;
      end else begin
        kind = 8'($urandom_range(0, 255));
      end
      build_record(line, count, addr, kind);

      if (pick < 70) begin
        if (kind == hrp_pkg::KIND_EOF) begin
          send_line(line, line.size(), 1'b0);
          repeat ($urandom_range(0, 5)) send_char(8'($urandom_range(0, 255)), 1'b0);
          send_char(CHAR_LF, 1'b1);
        end else begin
          send_line(line, line.size(), $urandom_range(0, 4) == 0);
        end
      end else if (pick < 85) begin
        send_line(line, $urandom_range(1, line.size()), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && bytes_due == 0) begin
      $display("hex_record_parser_unit regression: pass");
    end else begin
      $display("hex_record_parser_unit regression: fail");
    end
    $finish;
  end

endmodule
